[rtl/lcdn_pkg.sv]
`default_nettype none

package lcdn_pkg;

  // One request word as it arrives at the input queue.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
  } item_t;

  // One timed pin state as it leaves the result queue.
  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [3:0] nibble;
    logic [9:0] hold_ms;
    logic       last;
  } result_t;

  // Timing registers as seen by the bus sequencer.
  typedef struct packed {
    logic [5:0] pulse_ms;
    logic [5:0] nibble_gap_ms;
    logic [5:0] settle_ms;
    logic [7:0] powerup_ms;
    logic [7:0] clear_wait_ms;
  } cfg_t;

  // Request codes.
  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;
  localparam logic [1:0] MODE_POS  = 2'd3;

  // Extra settle time added to the last state of a byte.
  typedef enum logic [1:0] {
    EXTRA_NONE,
    EXTRA_ONE,
    EXTRA_CLEAR
  } extra_e;

  // One bus job: either the power-up wait or one byte in two nibbles.
  typedef struct packed {
    logic       is_wait;
    logic       reg_select;
    logic [7:0] byte_value;
    extra_e     extra;
    logic       last;
  } job_t;

  // Display addresses.
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  // Register reset values.
  localparam logic [5:0] PULSE_RST      = 6'd1;
  localparam logic [5:0] NIBBLE_GAP_RST = 6'd20;
  localparam logic [5:0] SETTLE_RST     = 6'd5;
  localparam logic [7:0] POWERUP_RST    = 8'd20;
  localparam logic [7:0] CLEAR_WAIT_RST = 8'd40;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PULSE      = 3'd0;
  localparam logic [2:0] REG_NIBBLE_GAP = 3'd1;
  localparam logic [2:0] REG_SETTLE     = 3'd2;
  localparam logic [2:0] REG_POWERUP    = 3'd3;
  localparam logic [2:0] REG_CLEAR_WAIT = 3'd4;

  // Command bytes of the power-up sequence; step 0 is the wait.
  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd1:    b = 8'h33;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h28;
      3'd4:    b = 8'h0E;
      3'd5:    b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  // Extra time after each byte of the power-up sequence.
  function automatic extra_e init_extra(input logic [2:0] step);
    extra_e e;
    unique case (step)
      3'd1, 3'd2, 3'd3, 3'd4: e = EXTRA_ONE;
      3'd5:                   e = EXTRA_NONE;
      default:                e = EXTRA_CLEAR;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/char_lcd_nibble_interface.sv]
// An accepted word passes the front end's request register, the job queue, the back end's job
// register and the output register before its first pin state shows on the result ports.
// Throughput: set by the bus sequencer, one pin state per cycle while the result side pops;
// a byte is four pin states, init 25, a wrapping character eight. The request front end
// expands one job per cycle into a four-entry job queue while it has room. Reset: timing
// registers take their defaults, cursor goes to row 1 column 0, and both queues are emptied.
`default_nettype none

module char_lcd_nibble_interface
  import lcdn_pkg::*;
#(
  parameter int ROW_WIDTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire item_t      item_i,
  output logic            empty,
  input  wire logic       pop,
  output result_t         result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  cfg_t cfg_q;
  job_t front_job;
  logic front_valid;
  logic fifo_full;
  logic fifo_push;
  job_t fifo_job;
  logic fifo_empty;
  logic fifo_pop;

  // Timing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ms      <= PULSE_RST;
      cfg_q.nibble_gap_ms <= NIBBLE_GAP_RST;
      cfg_q.settle_ms     <= SETTLE_RST;
      cfg_q.powerup_ms    <= POWERUP_RST;
      cfg_q.clear_wait_ms <= CLEAR_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PULSE:      cfg_q.pulse_ms      <= cfg_data_i[5:0];
        REG_NIBBLE_GAP: cfg_q.nibble_gap_ms <= cfg_data_i[5:0];
        REG_SETTLE:     cfg_q.settle_ms     <= cfg_data_i[5:0];
        REG_POWERUP:    cfg_q.powerup_ms    <= cfg_data_i;
        REG_CLEAR_WAIT: cfg_q.clear_wait_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fifo_push = front_valid && !fifo_full;

  lcdn_front #(
    .ROW_WIDTH(ROW_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .job_o      (front_job),
    .job_valid_o(front_valid),
    .job_ready_i(!fifo_full)
  );

  lcdn_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (fifo_push),
    .wr_job_i(front_job),
    .full_o  (fifo_full),
    .rd_en_i (fifo_pop),
    .rd_job_o(fifo_job),
    .empty_o (fifo_empty)
  );

  lcdn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_i      (fifo_job),
    .job_avail_i(!fifo_empty),
    .job_take_o (fifo_pop),
    .result_o   (result_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

`default_nettype wire

[rtl/lcdn_front.sv]
`default_nettype none

module lcdn_front
  import lcdn_pkg::*;
#(
  parameter int ROW_WIDTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output job_t       job_o,
  output logic       job_valid_o,
  input  wire logic  job_ready_i
);

  localparam logic [7:0] RowWidthC = 8'(ROW_WIDTH);
  localparam logic [2:0] InitLastStep = 3'd6;

  logic       cur_valid_q, cur_valid_d;
  logic [1:0] cur_mode_q, cur_mode_d;
  logic [7:0] cur_byte_q, cur_byte_d;
  logic [2:0] step_q, step_d;
  logic [2:0] last_step_q, last_step_d;
  logic       second_row_q, second_row_d;
  logic [7:0] col_cnt_q, col_cnt_d;

  logic       emit;
  logic       final_step;
  logic       accept;
  logic [7:0] col_inc;
  logic       wrap;
  logic       pos_valid;
  logic [7:0] pos_addr;

  assign final_step  = (step_q == last_step_q);
  assign emit        = cur_valid_q && job_ready_i;
  assign job_valid_o = cur_valid_q;
  assign full_o      = cur_valid_q && !(emit && final_step);
  assign accept      = push_i && !full_o;

  // Cursor bookkeeping for a data character.
  assign col_inc = col_cnt_q + 8'd1;
  assign wrap    = (col_inc == RowWidthC) && !second_row_q;

  // Position command address; rows other than 1 and 2 produce nothing.
  assign pos_valid = (item_i.row == 2'd1) || (item_i.row == 2'd2);
  assign pos_addr  = ((item_i.row == 2'd1) ? ROW1_BASE : ROW2_BASE) + {2'b00, item_i.column};

  // Job for the current step of the held request.
  always_comb begin
    job_o            = '0;
    job_o.extra      = EXTRA_NONE;
    job_o.last       = final_step;
    job_o.byte_value = cur_byte_q;
    unique case (cur_mode_q)
      MODE_INIT: begin
        job_o.is_wait    = (step_q == 3'd0);
        job_o.byte_value = init_byte(step_q);
        job_o.extra      = init_extra(step_q);
      end
      MODE_DATA: begin
        if (step_q == 3'd0) begin
          job_o.reg_select = 1'b1;
        end else begin
          job_o.byte_value = ROW2_BASE;
        end
      end
      default: begin
        job_o.reg_select = 1'b0;
      end
    endcase
  end

  // Request expansion and cursor state update.
  always_comb begin
    cur_valid_d  = cur_valid_q;
    cur_mode_d   = cur_mode_q;
    cur_byte_d   = cur_byte_q;
    step_d       = step_q;
    last_step_d  = last_step_q;
    second_row_d = second_row_q;
    col_cnt_d    = col_cnt_q;

    if (emit) begin
      if (final_step) begin
        cur_valid_d = 1'b0;
      end else begin
        step_d = step_q + 3'd1;
      end
    end

    if (accept) begin
      cur_mode_d = item_i.mode;
      cur_byte_d = item_i.byte_value;
      step_d     = 3'd0;
      unique case (item_i.mode)
        MODE_INIT: begin
          cur_valid_d = 1'b1;
          last_step_d = InitLastStep;
        end
        MODE_CMD: begin
          cur_valid_d = 1'b1;
          last_step_d = 3'd0;
        end
        MODE_DATA: begin
          cur_valid_d  = 1'b1;
          last_step_d  = wrap ? 3'd1 : 3'd0;
          col_cnt_d    = wrap ? 8'd0 : col_inc;
          second_row_d = second_row_q || wrap;
        end
        default: begin
          cur_valid_d = pos_valid;
          cur_byte_d  = pos_addr;
          last_step_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      step_q       <= '0;
      last_step_q  <= '0;
      second_row_q <= 1'b0;
      col_cnt_q    <= '0;
    end else begin
      cur_valid_q  <= cur_valid_d;
      step_q       <= step_d;
      last_step_q  <= last_step_d;
      second_row_q <= second_row_d;
      col_cnt_q    <= col_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_mode_q <= cur_mode_d;
    cur_byte_q <= cur_byte_d;
  end

  // The step counter never runs past the request's final job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (step_q <= last_step_q))
    else $error("front step past final job");

endmodule

`default_nettype wire

[rtl/lcdn_job_fifo.sv]
`default_nettype none

module lcdn_job_fifo
  import lcdn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_en_i,
  input  wire job_t wr_job_i,
  output logic      full_o,
  input  wire logic rd_en_i,
  output job_t      rd_job_o,
  output logic      empty_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o   = (count_q == (PtrW + 1)'(Depth));
  assign empty_o  = (count_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW + 1)'(wr_en_i) - (PtrW + 1)'(rd_en_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> !full_o)
    else $error("job queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

[rtl/lcdn_back.sv]
`default_nettype none

module lcdn_back
  import lcdn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire job_t job_i,
  input  wire logic job_avail_i,
  output logic      job_take_o,
  output result_t   result_o,
  output logic      empty_o,
  input  wire logic pop_i
);

  logic       job_valid_q;
  job_t       job_q;
  logic [1:0] phase_q;
  logic       out_valid_q;
  result_t    out_q;

  logic       out_load;
  logic       adv;
  logic       final_state;
  result_t    state;
  logic [9:0] extra_ms;

  assign out_load    = !out_valid_q || pop_i;
  assign adv         = job_valid_q && out_load;
  assign final_state = job_q.is_wait || (phase_q == 2'd3);
  assign job_take_o  = job_avail_i && (!job_valid_q || (adv && final_state));

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  // Extra time after the lower nibble of a byte.
  always_comb begin
    unique case (job_q.extra)
      EXTRA_ONE:   extra_ms = 10'd1;
      EXTRA_CLEAR: extra_ms = {2'b00, cfg_i.clear_wait_ms};
      default:     extra_ms = '0;
    endcase
  end

  // Pin state for the current phase of the current job.
  always_comb begin
    state            = '0;
    state.read_write = 1'b0;
    state.last       = job_q.last && final_state;
    if (job_q.is_wait) begin
      state.hold_ms = {2'b00, cfg_i.powerup_ms};
    end else begin
      state.reg_select = job_q.reg_select;
      state.enable     = !phase_q[0];
      state.nibble     = phase_q[1] ? job_q.byte_value[3:0] : job_q.byte_value[7:4];
      unique case (phase_q)
        2'd1:    state.hold_ms = {4'b0, cfg_i.pulse_ms} + {4'b0, cfg_i.nibble_gap_ms};
        2'd3:    state.hold_ms = {4'b0, cfg_i.pulse_ms} + {4'b0, cfg_i.settle_ms} + extra_ms;
        default: state.hold_ms = {4'b0, cfg_i.pulse_ms};
      endcase
    end
  end

  // Job register and nibble phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_take_o) begin
        job_valid_q <= 1'b1;
        phase_q     <= '0;
      end else if (adv) begin
        if (final_state) begin
          job_valid_q <= 1'b0;
          phase_q     <= '0;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end
      if (out_load) begin
        out_valid_q <= adv;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_q <= state;
    end
  end

  // A wait job is a single state and never advances past its first phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && job_q.is_wait) |-> (phase_q == 2'd0))
    else $error("wait job advanced a phase");

endmodule

`default_nettype wire

[sim/char_lcd_nibble_interface_test.sv]
`default_nettype none

module char_lcd_nibble_interface_test;
  import lcdn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int LINE_WIDTH     = 16;
  localparam int QUIET_CYCLES   = 12;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  // Register select levels on the LCD bus.
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Rows that a position request acts on.
  localparam logic [1:0] ROW_FIRST  = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;

  // Index that decodes to no register.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Power-up command bytes: function set three times, display on, entry mode, clear.
  localparam logic [7:0] INIT_CMDS [6] = '{8'h33, 8'h32, 8'h28, 8'h0E, 8'h06, 8'h01};

  // Tracks the cursor and timing registers and predicts the pin states of each word.
  class lcd_pin_board;
    cfg_t       timing;
    logic       on_second_row;
    logic [7:0] column_count;
    result_t    pin_states[$];
    int         mismatches;

    function new();
      timing.pulse_ms      = PULSE_RST;
      timing.nibble_gap_ms = NIBBLE_GAP_RST;
      timing.settle_ms     = SETTLE_RST;
      timing.powerup_ms    = POWERUP_RST;
      timing.clear_wait_ms = CLEAR_WAIT_RST;
      on_second_row = 1'b0;
      column_count  = 8'd0;
      mismatches    = 0;
    endfunction

    function void set_timing(logic [2:0] idx, logic [7:0] data);
      case (idx)
        REG_PULSE:      timing.pulse_ms      = data[5:0];
        REG_NIBBLE_GAP: timing.nibble_gap_ms = data[5:0];
        REG_SETTLE:     timing.settle_ms     = data[5:0];
        REG_POWERUP:    timing.powerup_ms    = data;
        REG_CLEAR_WAIT: timing.clear_wait_ms = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pin_states.size();
    endfunction

    function void add_state(logic rs, logic en, logic [3:0] nib, logic [9:0] hold);
      result_t s;
      s = '0;
      s.reg_select = rs;
      s.enable     = en;
      s.nibble     = nib;
      s.hold_ms    = hold;
      pin_states.push_back(s);
    endfunction

    // A byte is two nibbles, each an enable pulse followed by a low state.
    function void add_byte(logic rs, logic [7:0] b, logic [9:0] extra);
      logic [9:0] pulse;
      pulse = 10'(timing.pulse_ms);
      add_state(rs, 1'b1, b[7:4], pulse);
      add_state(rs, 1'b0, b[7:4], pulse + 10'(timing.nibble_gap_ms));
      add_state(rs, 1'b1, b[3:0], pulse);
      add_state(rs, 1'b0, b[3:0], pulse + 10'(timing.settle_ms) + extra);
    endfunction

    function void note_request(item_t r);
      int         prev_size;
      logic [9:0] extra;
      prev_size = pin_states.size();
      case (r.mode)
        MODE_INIT: begin
          add_state(RS_CMD, 1'b0, 4'h0, 10'(timing.powerup_ms));
          for (int i = 0; i < 6; i++) begin
            if (i < 4) extra = 10'd1;
            else if (i == 4) extra = 10'd0;
            else extra = 10'(timing.clear_wait_ms);
            add_byte(RS_CMD, INIT_CMDS[i], extra);
          end
        end
        MODE_CMD: add_byte(RS_CMD, r.byte_value, 10'd0);
        MODE_DATA: begin
          add_byte(RS_DATA, r.byte_value, 10'd0);
          column_count = column_count + 8'd1;
          // Running off the end of row 1 moves the cursor to the start of row 2.
          if (column_count == 8'(LINE_WIDTH) && !on_second_row) begin
            on_second_row = 1'b1;
            column_count  = 8'd0;
            add_byte(RS_CMD, ROW2_BASE, 10'd0);
          end
        end
        MODE_POS: begin
          if (r.row == ROW_FIRST) add_byte(RS_CMD, ROW1_BASE + {2'b00, r.column}, 10'd0);
          else if (r.row == ROW_SECOND) add_byte(RS_CMD, ROW2_BASE + {2'b00, r.column}, 10'd0);
        end
        default: ;
      endcase
      if (pin_states.size() > prev_size) pin_states[pin_states.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [9:0] got, logic [9:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_state(result_t got);
      result_t want;
      if (pin_states.size() == 0) begin
        report_mismatch($sformatf("pin state %p with nothing expected", got));
        return;
      end
      want = pin_states.pop_front();
      compare_field("reg_select", 10'(got.reg_select), 10'(want.reg_select));
      compare_field("read_write", 10'(got.read_write), 10'(want.read_write));
      compare_field("enable", 10'(got.enable), 10'(want.enable));
      compare_field("nibble", 10'(got.nibble), 10'(want.nibble));
      compare_field("hold_ms", got.hold_ms, want.hold_ms);
      compare_field("last", 10'(got.last), 10'(want.last));
    endtask
  endclass

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       push       = 1'b0;
  logic       full;
  item_t      item_i     = '0;
  logic       empty;
  logic       pop        = 1'b0;
  result_t    result_o;
  logic       cfg_we_i   = 1'b0;
  logic [2:0] cfg_idx_i  = '0;
  logic [7:0] cfg_data_i = '0;

  lcd_pin_board board;
  bit           idling_on        = 1'b1;
  bit           hold_off_request = 1'b0;
  int           quiet_cycles     = 0;

  char_lcd_nibble_interface #(.ROW_WIDTH(LINE_WIDTH)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Offers one word and waits for the edge that takes it; push stays high afterward.
  task automatic send_request(input item_t r);
    push   <= 1'b1;
    item_i <= r;
    do @(posedge clk_i); while (full);
    board.note_request(r);
  endtask

  task automatic pause_sender(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every predicted pin state has been popped and the block has gone quiet.
  task automatic drain_results();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_timing(idx, data);
  endtask

  // Writes all timing registers, plus one write to an index with no register behind it.
  task automatic apply_timing(input logic [7:0] pulse, gap, settle, powerup, clear_wait);
    write_register(REG_PULSE, pulse);
    write_register(REG_NIBBLE_GAP, gap);
    write_register(REG_SETTLE, settle);
    write_register(REG_POWERUP, powerup);
    write_register(REG_CLEAR_WAIT, clear_wait);
    write_register(REG_UNUSED, 8'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly characters, commands and positions; init now and then.
  function automatic item_t random_request();
    item_t r;
    int    pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) r.mode = MODE_INIT;
    else if (pick <= 5) r.mode = MODE_CMD;
    else if (pick <= 13) r.mode = MODE_DATA;
    else r.mode = MODE_POS;
    r.byte_value = 8'($urandom);
    r.row        = 2'($urandom);
    r.column     = 6'($urandom);
    return r;
  endfunction

  function automatic item_t make_request(logic [1:0] mode, logic [7:0] b,
                                         logic [1:0] row, logic [5:0] column);
    item_t r;
    r.mode       = mode;
    r.byte_value = b;
    r.row        = row;
    r.column     = column;
    return r;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_request());
      if (idling_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 5));
    end
  endtask

  // Result side: checks each popped pin state and stalls in random bursts.
  initial begin : result_drain
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) board.check_state(result_o);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        pop <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Ends the run when no word has moved on any port for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset timing: init, byte extremes, both rows, ignored rows,
    // then enough characters to run off the end of row 1.
    send_request(make_request(MODE_INIT, 8'($urandom), 2'($urandom), 6'($urandom)));
    send_request(make_request(MODE_CMD, 8'h00, 2'd0, 6'd0));
    send_request(make_request(MODE_CMD, 8'hFF, 2'd3, 6'd63));
    send_request(make_request(MODE_DATA, 8'h00, 2'd0, 6'd0));
    pause_sender(3);
    send_request(make_request(MODE_DATA, 8'hFF, 2'd3, 6'd63));
    send_request(make_request(MODE_POS, 8'h00, ROW_FIRST, 6'd0));
    send_request(make_request(MODE_POS, 8'hFF, ROW_FIRST, 6'd63));
    send_request(make_request(MODE_POS, 8'h00, ROW_SECOND, 6'd0));
    send_request(make_request(MODE_POS, 8'hFF, ROW_SECOND, 6'd63));
    send_request(make_request(MODE_POS, 8'($urandom), 2'd0, 6'($urandom)));
    send_request(make_request(MODE_POS, 8'($urandom), 2'd3, 6'($urandom)));
    for (int i = 0; i < LINE_WIDTH - 2; i++) begin
      send_request(make_request(MODE_DATA, 8'($urandom), 2'($urandom), 6'($urandom)));
    end
    drain_results();

    // Shortest possible timing.
    apply_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_random(70);
    drain_results();

    // Longest timing; the upper data bits of the 6-bit registers are dropped. The result
    // side holds off for a long stretch while words keep coming, so the input backs up.
    apply_timing(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    hold_off_request = 1'b1;
    for (int i = 0; i < 30; i++) send_request(random_request());
    send_random(40);
    drain_results();

    // Random timing, twice.
    for (int p = 0; p < 2; p++) begin
      apply_timing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_random(70);
      drain_results();
    end

    // Back to the reset timing with both sides running flat out.
    apply_timing(8'(PULSE_RST), 8'(NIBBLE_GAP_RST), 8'(SETTLE_RST), POWERUP_RST,
                 CLEAR_WAIT_RST);
    idling_on = 1'b0;
    send_random(95);
    drain_results();

    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
